>>> rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 8;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIO     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD = 1'b1;

  localparam logic [PRIO_W-1:0] MAX_PRIO_RST     = 4'd5;
  localparam logic [CNT_W-1:0]  BOOST_PERIOD_RST = 8'd5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_YIELD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_SCHEDULED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   next_slot;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   chosen_priority;
  } out_t;

endpackage

>>> rtl/mlfq_prio_ram.sv
// ----------------------------------------------------------------------------
// mlfq_prio_ram
// Priority table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfq_prio_ram #(
  parameter int unsigned DEPTH = mlfq_pkg::SLOTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = mlfq_pkg::PRIO_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: runnable marks, boost timer, table scan with read-modify-write.
// ----------------------------------------------------------------------------
module mlfq_ctrl #(
  parameter int unsigned SLOTS = mlfq_pkg::SLOTS_DEF,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mlfq_pkg::in_t                 in_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output mlfq_pkg::out_t                res_o,
  input  logic [mlfq_pkg::PRIO_W-1:0]   max_prio_i,
  input  logic [mlfq_pkg::CNT_W-1:0]    boost_period_i,
  output logic                          ram_we_o,
  output logic [IDX_W-1:0]              ram_waddr_o,
  output logic [mlfq_pkg::PRIO_W-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [IDX_W-1:0]              ram_raddr_o,
  input  logic [mlfq_pkg::PRIO_W-1:0]   ram_rdata_i
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [SLOTS-1:0]              run_q, run_d;
  logic [IDX_W-1:0]              cur_q, cur_d;
  logic                          cur_vld_q, cur_vld_d;
  logic [mlfq_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          boost_q, boost_d;
  logic                          tick_q, tick_d;
  logic [CW-1:0]                 rd_cnt_q, rd_cnt_d;
  logic                          pend_q, pend_d;
  logic [IDX_W-1:0]              pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]              best_q, best_d;
  logic [mlfq_pkg::PRIO_W-1:0]   best_pri_q, best_pri_d;
  logic                          found_q, found_d;
  logic [mlfq_pkg::PRIO_W-1:0]   cur_pri_q, cur_pri_d;
  mlfq_pkg::out_t                res_q, res_d;

  logic                          accept;
  logic                          start_scan;
  logic [mlfq_pkg::CNT_W-1:0]    cnt_dec;
  logic [IDX_W-1:0]              slot_idx;
  logic                          slot_ok;
  logic                          pend_run;
  logic [mlfq_pkg::PRIO_W-1:0]   eff_pri;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign accept      = in_valid_i && in_ready_o;

  assign cnt_dec  = cnt_q - mlfq_pkg::CNT_W'(1);
  assign slot_idx = IDX_W'(in_data_i.slot);
  assign slot_ok  = (32'(in_data_i.slot) < SLOTS);
  assign pend_run = run_q[pend_idx_q];
  // boosted runnable slots see max priority during this scan
  assign eff_pri  = (boost_q && pend_run) ? max_prio_i : ram_rdata_i;

  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    cur_d      = cur_q;
    cur_vld_d  = cur_vld_q;
    cnt_d      = cnt_q;
    boost_d    = boost_q;
    tick_d     = tick_q;
    rd_cnt_d   = rd_cnt_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    best_d     = best_q;
    best_pri_d = best_pri_q;
    found_d    = found_q;
    cur_pri_d  = cur_pri_q;
    res_d      = res_q;
    start_scan = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = pend_idx_q;
    ram_wdata_o = max_prio_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_cnt_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.func)
            mlfq_pkg::FUNC_TICK: begin
              tick_d     = 1'b1;
              start_scan = 1'b1;
              if (cnt_dec == '0) begin
                boost_d = 1'b1;
                cnt_d   = boost_period_i;
              end else begin
                boost_d = 1'b0;
                cnt_d   = cnt_dec;
              end
            end
            mlfq_pkg::FUNC_YIELD: begin
              tick_d     = 1'b0;
              boost_d    = 1'b0;
              start_scan = 1'b1;
            end
            mlfq_pkg::FUNC_ADD: begin
              if (slot_ok) begin
                ram_we_o        = 1'b1;
                ram_waddr_o     = slot_idx;
                ram_wdata_o     = max_prio_i;
                run_d[slot_idx] = 1'b1;
              end
              res_d   = '{next_slot:       mlfq_pkg::SLOT_W'(cur_q),
                          status:          mlfq_pkg::STATUS_UPDATED,
                          chosen_priority: '0};
              state_d = S_DONE;
            end
            mlfq_pkg::FUNC_REMOVE: begin
              if (slot_ok) begin
                run_d[slot_idx] = 1'b0;
              end
              res_d   = '{next_slot:       mlfq_pkg::SLOT_W'(cur_q),
                          status:          mlfq_pkg::STATUS_UPDATED,
                          chosen_priority: '0};
              state_d = S_DONE;
            end
            default: ;
          endcase
        end
        if (start_scan) begin
          rd_cnt_d   = '0;
          pend_d     = 1'b0;
          best_d     = cur_q;
          best_pri_d = '0;
          found_d    = 1'b0;
          cur_pri_d  = '0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // read slot n while slot n-1's data is evaluated and boosted
        if (rd_cnt_q != CW'(SLOTS)) begin
          ram_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_cnt_q[IDX_W-1:0];
          rd_cnt_d   = rd_cnt_q + CW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_EVAL;
        end
        if (pend_q) begin
          if (boost_q && pend_run) begin
            ram_we_o = 1'b1;
          end
          if (pend_run) begin
            if (!cur_vld_q) begin
              if (!found_q) begin
                found_d    = 1'b1;
                best_d     = pend_idx_q;
                best_pri_d = eff_pri;
              end
            end else if (eff_pri > best_pri_q) begin
              best_d     = pend_idx_q;
              best_pri_d = eff_pri;
            end
          end
          if (pend_idx_q == cur_q) begin
            cur_pri_d = eff_pri;
          end
        end
      end

      S_EVAL: begin
        if (run_q == '0) begin
          res_d = '{next_slot:       mlfq_pkg::SLOT_W'(cur_q),
                    status:          mlfq_pkg::STATUS_EMPTY,
                    chosen_priority: '0};
        end else begin
          res_d = '{next_slot:       mlfq_pkg::SLOT_W'(best_q),
                    status:          mlfq_pkg::STATUS_SCHEDULED,
                    chosen_priority: (best_q == cur_q) ? cur_pri_q : best_pri_q};
          // demote the slot that was running, after any boost write
          if (tick_q && cur_vld_q && (cur_pri_q != '0)) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = cur_q;
            ram_wdata_o = cur_pri_q - mlfq_pkg::PRIO_W'(1);
          end
          cur_d     = best_q;
          cur_vld_d = 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      run_q      <= '0;
      cur_q      <= '0;
      cur_vld_q  <= 1'b0;
      cnt_q      <= mlfq_pkg::BOOST_PERIOD_RST;
      pend_q     <= 1'b0;
      boost_q    <= 1'b0;
      tick_q     <= 1'b0;
      rd_cnt_q   <= '0;
      pend_idx_q <= '0;
      best_q     <= '0;
      best_pri_q <= '0;
      found_q    <= 1'b0;
      cur_pri_q  <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      run_q      <= run_d;
      cur_q      <= cur_d;
      cur_vld_q  <= cur_vld_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      boost_q    <= boost_d;
      tick_q     <= tick_d;
      rd_cnt_q   <= rd_cnt_d;
      pend_idx_q <= pend_idx_d;
      best_q     <= best_d;
      best_pri_q <= best_pri_d;
      found_q    <= found_d;
      cur_pri_q  <= cur_pri_d;
      res_q      <= res_d;
    end
  end

endmodule

>>> rtl/mlfq_priority_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_priority_scheduler
// Multilevel feedback queue scheduler over SLOTS task slots.
// ----------------------------------------------------------------------------
// Tick / yield: the controller scans every slot, then evaluates, and the
//   result is passed to the output register; the next transaction is taken
//   once the result has left the controller. The scan length is set by the
//   single read port of the priority RAM, one slot per cycle in the scan.
// Add / remove: result registered in the controller, then passed to the output register; next one after that.
// Reset (async, active low): marks clear, no task running, timer and both
//   config registers at 5. The priority RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module mlfq_priority_scheduler #(
  parameter int unsigned SLOTS = mlfq_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input transactions
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mlfq_pkg::in_t                   in_data_i,
  // result transactions
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mlfq_pkg::out_t                  out_data_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // Config registers
  logic [mlfq_pkg::PRIO_W-1:0] max_prio_q;
  logic [mlfq_pkg::CNT_W-1:0]  boost_period_q;

  // Controller result handshake
  logic           res_valid;
  logic           res_ready;
  mlfq_pkg::out_t res;

  // Output register: holds a finished result while the controller moves on
  logic           out_valid_q;
  mlfq_pkg::out_t out_q;

  // RAM ports
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [mlfq_pkg::PRIO_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [mlfq_pkg::PRIO_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_prio_q     <= mlfq_pkg::MAX_PRIO_RST;
      boost_period_q <= mlfq_pkg::BOOST_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlfq_pkg::CFG_MAX_PRIO:     max_prio_q     <= cfg_wdata_i[mlfq_pkg::PRIO_W-1:0];
        mlfq_pkg::CFG_BOOST_PERIOD: boost_period_q <= cfg_wdata_i[mlfq_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new result when the register is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mlfq_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .max_prio_i     (max_prio_q),
    .boost_period_i (boost_period_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Scan reads slot n while writing slot n-1, and the demotion write
  // follows the scan, so a read and a write never hit the same entry.
  mlfq_prio_ram #(
    .DEPTH (SLOTS),
    .AW    (IDX_W),
    .DW    (mlfq_pkg::PRIO_W)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
